// ===== sv/gsab_pkg.sv =====
// gsab_pkg: shared types, constants and helper functions of the splat blend unit
// no dependencies; used by gsab_ctrl, gsab_dp and the top level
`default_nettype none

package gsab_pkg;

    // pixel store geometry
    localparam int PIX_ADDR_W = 16;
    localparam int PIX_DEPTH  = 65536;

    // exp table geometry
    localparam int EXP_ADDR_W  = 10;
    localparam int EXP_ENTRIES = 1024;

    // exp(-1/32) in Q0.32, one step of the table recurrence
    localparam logic [31:0] EXP_STEP_Q32 = 32'd4162825044;

    // one in Q1.16
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // register reset values
    localparam logic [16:0] MAX_ALPHA_RST    = 17'd64880;
    localparam logic [16:0] MIN_ALPHA_RST    = 17'd257;
    localparam logic [23:0] POWER_CUTOFF_RST = 24'hE20000;

    // stream widths
    localparam int S_TDATA_W = 248;
    localparam int M_TDATA_W = 136;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ALPHA    = 2'd0,
        CFG_MIN_ALPHA    = 2'd1,
        CFG_POWER_CUTOFF = 2'd2
    } cfg_idx_t;

    // one pixel store entry
    typedef struct packed {
        logic [15:0]        cnt;
        logic signed [31:0] depth;
        logic [16:0]        trans;
        logic signed [15:0] b;
        logic signed [15:0] g;
        logic signed [15:0] r;
    } pix_t;

    localparam int PIX_W = $bits(pix_t);

    // controller states
    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_CLEAR,
        ST_XX, ST_YY, ST_XY, ST_QA, ST_QC, ST_QB, ST_QS,
        ST_EVAL, ST_ALPHA, ST_CLAMP, ST_W, ST_R, ST_G, ST_B, ST_D, ST_COMMIT
    } state_t;

    // datapath operation steps
    typedef enum logic [4:0] {
        STEP_NONE,
        STEP_XX, STEP_YY, STEP_XY, STEP_QA, STEP_QC, STEP_QB, STEP_QS,
        STEP_EVAL, STEP_ALPHA, STEP_CLAMP, STEP_W, STEP_R, STEP_G, STEP_B, STEP_D,
        STEP_COMMIT
    } step_t;

    // controller to datapath
    typedef struct packed {
        logic  capture;
        logic  clear;
        logic  build;
        step_t step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic exp_done;
        logic new_frame;
        logic out_free;
    } status_t;

    // saturate to 16 bits signed
    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        logic signed [15:0] res;
        if (v > 34'sd32767)
            res = 16'sh7FFF;
        else if (v < -34'sd32768)
            res = 16'sh8000;
        else
            res = v[15:0];
        return res;
    endfunction

    // saturate to 32 bits signed
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] res;
        if (v > 35'sd2147483647)
            res = 32'sh7FFFFFFF;
        else if (v < -35'sd2147483648)
            res = 32'sh80000000;
        else
            res = v[31:0];
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/gsab_ram.sv =====
// gsab_ram: generic single write port RAM with one registered read port
// no dependencies
`default_nettype none

module gsab_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/gsab_ctrl.sv =====
// gsab_ctrl: sequencing state machine of the splat blend unit
// depends on gsab_pkg
`default_nettype none

module gsab_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire gsab_pkg::status_t status,
    output gsab_pkg::cmd_t        cmd
);

    gsab_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gsab_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gsab_pkg::ST_INIT:
            begin
                if (status.clr_last && status.exp_done)
                    state_next = gsab_pkg::ST_IDLE;
            end
            gsab_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = status.new_frame ? gsab_pkg::ST_CLEAR : gsab_pkg::ST_XX;
            end
            gsab_pkg::ST_CLEAR:
            begin
                if (status.clr_last)
                    state_next = gsab_pkg::ST_XX;
            end
            gsab_pkg::ST_XX:    state_next = gsab_pkg::ST_YY;
            gsab_pkg::ST_YY:    state_next = gsab_pkg::ST_XY;
            gsab_pkg::ST_XY:    state_next = gsab_pkg::ST_QA;
            gsab_pkg::ST_QA:    state_next = gsab_pkg::ST_QC;
            gsab_pkg::ST_QC:    state_next = gsab_pkg::ST_QB;
            gsab_pkg::ST_QB:    state_next = gsab_pkg::ST_QS;
            gsab_pkg::ST_QS:    state_next = gsab_pkg::ST_EVAL;
            gsab_pkg::ST_EVAL:  state_next = gsab_pkg::ST_ALPHA;
            gsab_pkg::ST_ALPHA: state_next = gsab_pkg::ST_CLAMP;
            gsab_pkg::ST_CLAMP: state_next = gsab_pkg::ST_W;
            gsab_pkg::ST_W:     state_next = gsab_pkg::ST_R;
            gsab_pkg::ST_R:     state_next = gsab_pkg::ST_G;
            gsab_pkg::ST_G:     state_next = gsab_pkg::ST_B;
            gsab_pkg::ST_B:     state_next = gsab_pkg::ST_D;
            gsab_pkg::ST_D:     state_next = gsab_pkg::ST_COMMIT;
            gsab_pkg::ST_COMMIT:
            begin
                if (status.out_free)
                    state_next = gsab_pkg::ST_IDLE;
            end
            default:            state_next = gsab_pkg::ST_INIT;
        endcase
    end

    // command outputs
    always_comb
    begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.clear   = 1'b0;
        cmd.build   = 1'b0;
        cmd.step    = gsab_pkg::STEP_NONE;
        unique case (state_reg)
            gsab_pkg::ST_INIT:
            begin
                cmd.clear = 1'b1;
                cmd.build = 1'b1;
            end
            gsab_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            gsab_pkg::ST_CLEAR:  cmd.clear = 1'b1;
            gsab_pkg::ST_XX:     cmd.step = gsab_pkg::STEP_XX;
            gsab_pkg::ST_YY:     cmd.step = gsab_pkg::STEP_YY;
            gsab_pkg::ST_XY:     cmd.step = gsab_pkg::STEP_XY;
            gsab_pkg::ST_QA:     cmd.step = gsab_pkg::STEP_QA;
            gsab_pkg::ST_QC:     cmd.step = gsab_pkg::STEP_QC;
            gsab_pkg::ST_QB:     cmd.step = gsab_pkg::STEP_QB;
            gsab_pkg::ST_QS:     cmd.step = gsab_pkg::STEP_QS;
            gsab_pkg::ST_EVAL:   cmd.step = gsab_pkg::STEP_EVAL;
            gsab_pkg::ST_ALPHA:  cmd.step = gsab_pkg::STEP_ALPHA;
            gsab_pkg::ST_CLAMP:  cmd.step = gsab_pkg::STEP_CLAMP;
            gsab_pkg::ST_W:      cmd.step = gsab_pkg::STEP_W;
            gsab_pkg::ST_R:      cmd.step = gsab_pkg::STEP_R;
            gsab_pkg::ST_G:      cmd.step = gsab_pkg::STEP_G;
            gsab_pkg::ST_B:      cmd.step = gsab_pkg::STEP_B;
            gsab_pkg::ST_D:      cmd.step = gsab_pkg::STEP_D;
            gsab_pkg::ST_COMMIT:
            begin
                if (status.out_free)
                    cmd.step = gsab_pkg::STEP_COMMIT;
            end
            default:
            begin
                cmd.step = gsab_pkg::STEP_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/gsab_dp.sv =====
// gsab_dp: datapath with shared multiplier, exp table builder, pixel store and result register
// depends on gsab_pkg and gsab_ram
`default_nettype none

module gsab_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire gsab_pkg::cmd_t                  cmd,
    output gsab_pkg::status_t                    status,
    input  wire logic [gsab_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                            s_tuser,
    output logic [gsab_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            cfg_wen,
    input  wire logic [gsab_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gsab_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // configuration registers
    logic [16:0]        max_alpha_reg, min_alpha_reg;
    logic signed [23:0] cutoff_reg;

    // captured fragment
    logic [15:0]        pix_idx_reg;
    logic signed [15:0] ox_reg, oy_reg;
    logic signed [31:0] ca_reg, cb_reg, cc_reg;
    logic [16:0]        opac_reg;
    logic signed [15:0] cr_reg, cg_reg, cbl_reg;
    logic signed [31:0] idep_reg;

    // working registers
    logic signed [65:0] prod_reg, prod_next;
    logic signed [32:0] mul_a, mul_b;
    logic [31:0]        xx_reg, yy_reg;
    logic signed [32:0] xy2_reg;
    logic signed [65:0] q_reg;
    logic               skip_reg, oot_reg;
    logic [16:0]        alpha_reg;
    logic               pass_reg, go_reg;
    logic [16:0]        w_reg;
    gsab_pkg::pix_t     cur_reg;
    logic signed [15:0] r_new_reg, g_new_reg, b_new_reg;
    logic signed [31:0] d_new_reg;

    // result register
    logic [gsab_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                           m_tuser_reg, m_tvalid_reg;

    // exp table builder
    logic [32:0] exp_t_reg;
    logic [10:0] exp_k_reg;
    logic        exp_ph_reg;
    logic [47:0] exp_plo_reg;
    logic [48:0] exp_phi;
    logic [65:0] exp_sum;
    logic [32:0] exp_round;
    logic [15:0] exp_entry;
    logic        exp_we;

    // pixel store sweep
    logic [gsab_pkg::PIX_ADDR_W-1:0] clr_cnt_reg;

    // memory ports
    logic                            pix_we;
    logic [gsab_pkg::PIX_ADDR_W-1:0] pix_waddr;
    gsab_pkg::pix_t                  pix_wdata, pix_rdata, pix_rst, entry_new;
    logic [gsab_pkg::EXP_ADDR_W-1:0] exp_raddr;
    logic [15:0]                     exp_rdata;

    // combinational helpers
    logic signed [65:0] cut66, lim66, rnd_sum;
    logic signed [33:0] inc;
    logic               q_pos;
    logic [17:0]        a18, a_max;
    logic [16:0]        alpha_next, w_next, t_new;
    logic [33:0]        t_sum;
    logic [15:0]        raw;
    logic               commit;

    assign commit = (cmd.step == gsab_pkg::STEP_COMMIT);

    // status to controller
    assign status.clr_last  = (clr_cnt_reg == {gsab_pkg::PIX_ADDR_W{1'b1}});
    assign status.exp_done  = exp_k_reg[10];
    assign status.new_frame = s_tuser;
    assign status.out_free  = !m_tvalid_reg || m_tready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_alpha_reg <= gsab_pkg::MAX_ALPHA_RST;
            min_alpha_reg <= gsab_pkg::MIN_ALPHA_RST;
            cutoff_reg    <= gsab_pkg::POWER_CUTOFF_RST;
        end
        else if (cfg_wen)
        begin
            unique case (gsab_pkg::cfg_idx_t'(cfg_index))
                gsab_pkg::CFG_MAX_ALPHA:    max_alpha_reg <= cfg_wdata[16:0];
                gsab_pkg::CFG_MIN_ALPHA:    min_alpha_reg <= cfg_wdata[16:0];
                gsab_pkg::CFG_POWER_CUTOFF: cutoff_reg    <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pix_idx_reg <= s_tdata[15:0];
            ox_reg      <= s_tdata[31:16];
            oy_reg      <= s_tdata[47:32];
            ca_reg      <= s_tdata[79:48];
            cb_reg      <= s_tdata[111:80];
            cc_reg      <= s_tdata[143:112];
            opac_reg    <= s_tdata[160:144];
            cr_reg      <= s_tdata[176:161];
            cg_reg      <= s_tdata[192:177];
            cbl_reg     <= s_tdata[208:193];
            idep_reg    <= s_tdata[240:209];
        end
    end

    // exp table builder: in one phase write an entry and register the low partial product, in the other advance t
    assign exp_round = exp_t_reg + 33'd32768;
    assign exp_entry = (exp_round[32:16] > 17'd65535) ? 16'hFFFF : exp_round[31:16];
    assign exp_we    = cmd.build && !exp_k_reg[10] && !exp_ph_reg;
    assign exp_phi   = 49'(exp_t_reg[32:16]) * 49'(gsab_pkg::EXP_STEP_Q32);
    assign exp_sum   = 66'(exp_plo_reg)
                     + {1'b0, exp_phi, 16'd0}
                     + 66'h80000000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_t_reg  <= 33'h100000000;
            exp_k_reg  <= '0;
            exp_ph_reg <= 1'b0;
        end
        else if (cmd.build && !exp_k_reg[10])
        begin
            exp_ph_reg <= !exp_ph_reg;
            if (exp_ph_reg)
            begin
                exp_t_reg <= exp_sum[64:32];
                exp_k_reg <= exp_k_reg + 11'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exp_we)
        begin
            exp_plo_reg <= 48'(exp_t_reg[15:0]) * 48'(gsab_pkg::EXP_STEP_Q32);
        end
    end

    // store sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.step)
            gsab_pkg::STEP_XX:
            begin
                mul_a = {{17{ox_reg[15]}}, ox_reg};
                mul_b = {{17{ox_reg[15]}}, ox_reg};
            end
            gsab_pkg::STEP_YY:
            begin
                mul_a = {{17{oy_reg[15]}}, oy_reg};
                mul_b = {{17{oy_reg[15]}}, oy_reg};
            end
            gsab_pkg::STEP_XY:
            begin
                mul_a = {{17{ox_reg[15]}}, ox_reg};
                mul_b = {{17{oy_reg[15]}}, oy_reg};
            end
            gsab_pkg::STEP_QA:
            begin
                mul_a = {ca_reg[31], ca_reg};
                mul_b = {1'b0, xx_reg};
            end
            gsab_pkg::STEP_QC:
            begin
                mul_a = {cc_reg[31], cc_reg};
                mul_b = {1'b0, yy_reg};
            end
            gsab_pkg::STEP_QB:
            begin
                mul_a = {cb_reg[31], cb_reg};
                mul_b = xy2_reg;
            end
            gsab_pkg::STEP_ALPHA:
            begin
                mul_a = {16'd0, opac_reg};
                mul_b = {17'd0, raw};
            end
            gsab_pkg::STEP_CLAMP:
            begin
                mul_a = {16'd0, alpha_next};
                mul_b = {16'd0, cur_reg.trans};
            end
            gsab_pkg::STEP_W:
            begin
                mul_a = {{17{cr_reg[15]}}, cr_reg};
                mul_b = {16'd0, w_next};
            end
            gsab_pkg::STEP_R:
            begin
                mul_a = {{17{cg_reg[15]}}, cg_reg};
                mul_b = {16'd0, w_reg};
            end
            gsab_pkg::STEP_G:
            begin
                mul_a = {{17{cbl_reg[15]}}, cbl_reg};
                mul_b = {16'd0, w_reg};
            end
            gsab_pkg::STEP_B:
            begin
                mul_a = {idep_reg[31], idep_reg};
                mul_b = {16'd0, w_reg};
            end
            gsab_pkg::STEP_D:
            begin
                mul_a = {16'd0, cur_reg.trans};
                mul_b = {16'd0, gsab_pkg::ONE_Q16 - alpha_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // power cutoff limit in q units and exp table index
    assign cut66     = {{42{cutoff_reg[23]}}, cutoff_reg};
    assign lim66     = -(cut66 <<< 9);
    assign q_pos     = !q_reg[65] && (q_reg != '0);
    assign exp_raddr = q_pos ? q_reg[29:20] : '0;
    assign raw       = oot_reg ? 16'd0 : exp_rdata;

    // alpha clamp and weight
    assign a18        = prod_reg[33:16];
    assign a_max      = (a18 > {1'b0, max_alpha_reg}) ? {1'b0, max_alpha_reg} : a18;
    assign alpha_next = (a_max > {1'b0, gsab_pkg::ONE_Q16}) ? gsab_pkg::ONE_Q16 : a_max[16:0];
    assign w_next     = prod_reg[32:16];

    // rounded increment of the previous product
    assign rnd_sum = prod_reg + 66'sd32768;
    assign inc     = rnd_sum[49:16];

    // new transmittance
    assign t_sum = prod_reg[33:0] + 34'd32768;
    assign t_new = t_sum[32:16];

    // step registers
    always_ff @(posedge clk)
    begin
        if (cmd.step != gsab_pkg::STEP_NONE)
        begin
            prod_reg <= prod_next;
        end
        unique case (cmd.step)
            gsab_pkg::STEP_YY:    xx_reg <= prod_reg[31:0];
            gsab_pkg::STEP_XY:
            begin
                yy_reg  <= prod_reg[31:0];
                cur_reg <= pix_rdata;
            end
            gsab_pkg::STEP_QA:    xy2_reg <= {prod_reg[31:0], 1'b0};
            gsab_pkg::STEP_QC:    q_reg <= prod_reg;
            gsab_pkg::STEP_QB:    q_reg <= q_reg + prod_reg;
            gsab_pkg::STEP_QS:    q_reg <= q_reg + prod_reg;
            gsab_pkg::STEP_EVAL:
            begin
                skip_reg <= (q_reg > lim66);
                oot_reg  <= q_pos && (q_reg[65:30] != '0);
            end
            gsab_pkg::STEP_CLAMP:
            begin
                alpha_reg <= alpha_next;
                pass_reg  <= !skip_reg && (alpha_next >= min_alpha_reg);
            end
            gsab_pkg::STEP_W:
            begin
                w_reg  <= w_next;
                go_reg <= pass_reg && (w_next != '0);
            end
            gsab_pkg::STEP_R:     r_new_reg <= gsab_pkg::sat16({{18{cur_reg.r[15]}}, cur_reg.r} + inc);
            gsab_pkg::STEP_G:     g_new_reg <= gsab_pkg::sat16({{18{cur_reg.g[15]}}, cur_reg.g} + inc);
            gsab_pkg::STEP_B:     b_new_reg <= gsab_pkg::sat16({{18{cur_reg.b[15]}}, cur_reg.b} + inc);
            gsab_pkg::STEP_D:
            begin
                d_new_reg <= gsab_pkg::sat32({{3{cur_reg.depth[31]}}, cur_reg.depth}
                                             + {inc[33], inc});
            end
            default:
            begin
            end
        endcase
    end

    // updated pixel entry
    always_comb
    begin
        entry_new = cur_reg;
        if (go_reg)
        begin
            entry_new.r     = r_new_reg;
            entry_new.g     = g_new_reg;
            entry_new.b     = b_new_reg;
            entry_new.depth = d_new_reg;
            entry_new.trans = t_new;
            entry_new.cnt   = (cur_reg.cnt == 16'hFFFF) ? cur_reg.cnt : cur_reg.cnt + 16'd1;
        end
    end

    // pixel store write port: sweep or commit
    always_comb
    begin
        pix_rst       = '0;
        pix_rst.trans = gsab_pkg::ONE_Q16;
    end

    assign pix_we    = cmd.clear || (commit && go_reg);
    assign pix_waddr = cmd.clear ? clr_cnt_reg : pix_idx_reg;
    assign pix_wdata = cmd.clear ? pix_rst : entry_new;

    gsab_ram #(
        .WIDTH (gsab_pkg::PIX_W),
        .DEPTH (gsab_pkg::PIX_DEPTH)
    ) u_pix_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (pix_wdata),
        .raddr (pix_idx_reg),
        .rdata (pix_rdata)
    );

    gsab_ram #(
        .WIDTH (16),
        .DEPTH (gsab_pkg::EXP_ENTRIES)
    ) u_exp_ram (
        .clk   (clk),
        .we    (exp_we),
        .waddr (exp_k_reg[gsab_pkg::EXP_ADDR_W-1:0]),
        .wdata (exp_entry),
        .raddr (exp_raddr),
        .rdata (exp_rdata)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (commit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            m_tdata_reg <= {7'd0, entry_new.cnt, entry_new.depth, entry_new.trans,
                            entry_new.b, entry_new.g, entry_new.r, pix_idx_reg};
            m_tuser_reg <= go_reg;
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

// ===== sv/gaussian_splat_alpha_blend_unit.sv =====
// gaussian_splat_alpha_blend_unit: top level, controller plus datapath
// depends on gsab_pkg, gsab_ctrl, gsab_dp (and gsab_ram through gsab_dp)
// an item runs the datapath steps XX, YY, XY, QA, QC, QB, QS, EVAL, ALPHA, CLAMP, W, R,
// G, B and D, then COMMIT loads the result register once the output is free;
// no item is taken until then; new_frame adds a sweep that rewrites every pixel store entry
// reset: after rst_n rises, a sweep clears the pixel store while the builder fills
// the exp table; no item is accepted until both end, configuration writes are taken
`default_nettype none

module gaussian_splat_alpha_blend_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // pixel_index, offset_x, offset_y, conic_a, conic_b, conic_c, opacity,
    // red_in, green_in, blue_in, splat_inverse_depth, zero pad
    input  wire logic [gsab_pkg::S_TDATA_W-1:0]  s_tdata,
    // new_frame
    input  wire logic                            s_tuser,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // pixel_out, red_sum, green_sum, blue_sum, transmittance,
    // inverse_depth_sum, contributors, zero pad
    output logic [gsab_pkg::M_TDATA_W-1:0]       m_tdata,
    // blended
    output logic                                 m_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            cfg_wen,
    input  wire logic [gsab_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gsab_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    gsab_pkg::cmd_t    cmd;
    gsab_pkg::status_t status;

    gsab_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gsab_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for gaussian_splat_alpha_blend_unit, stream in and out
// depends on gsab_pkg and the rtl top level; predicts every blended pixel result
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // one splat fragment as offered on the input stream
    typedef struct {
        logic [15:0]        pixel;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [31:0] ca;
        logic signed [31:0] cb;
        logic signed [31:0] cc;
        logic [16:0]        opac;
        logic signed [15:0] red;
        logic signed [15:0] green;
        logic signed [15:0] blue;
        logic signed [31:0] inv_depth;
        logic               new_frame;
    } frag_t;

    // one pixel result as expected on the output stream
    typedef struct {
        logic [15:0]        pixel;
        logic               blended;
        logic signed [15:0] red;
        logic signed [15:0] green;
        logic signed [15:0] blue;
        logic [16:0]        trans;
        logic signed [31:0] inv_depth;
        logic [15:0]        contrib;
    } pix_result_t;

    logic                            clk;
    logic                            rst_n;
    logic [gsab_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                            s_tuser;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [gsab_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic                            cfg_wen;
    logic [gsab_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [gsab_pkg::CFG_DATA_W-1:0] cfg_wdata;

    frag_t          frag_q[$];
    pix_result_t    expected_q[$];
    gsab_pkg::pix_t pixel_mem[int];
    logic [15:0]    exp_lut[gsab_pkg::EXP_ENTRIES];

    logic [16:0] alpha_hi;
    logic [16:0] alpha_lo;
    longint      cutoff;

    int unsigned frags_in;
    int unsigned errors;
    logic        hold_off;

    gaussian_splat_alpha_blend_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // exp(-k/32) table in Q0.16, same recurrence as the hardware build
    function automatic void build_exp_lut();
        longint unsigned t;
        longint unsigned e;
        t = 64'd1 << 32;
        for (int k = 0; k < gsab_pkg::EXP_ENTRIES; k++)
        begin
            e = (t + 64'd32768) >> 16;
            exp_lut[k] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
            t = (t * longint'(gsab_pkg::EXP_STEP_Q32) + (64'd1 << 31)) >> 32;
        end
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // composite one fragment onto its pixel and return the pixel after it
    function automatic pix_result_t composite(input frag_t f);
        pix_result_t     res;
        gsab_pkg::pix_t  p;
        longint          ox, oy, q, w, inc;
        longint unsigned idx, raw, alpha;
        ox = f.dx;
        oy = f.dy;
        if (f.new_frame)
            pixel_mem.delete();
        if (pixel_mem.exists(f.pixel))
            p = pixel_mem[f.pixel];
        else
        begin
            p = '0;
            p.trans = gsab_pkg::ONE_Q16;
        end
        res.blended = 1'b0;
        q = longint'(f.ca) * (ox * ox) + longint'(f.cc) * (oy * oy)
            + longint'(f.cb) * (2 * ox * oy);
        if (!(q > -cutoff * 512))
        begin
            idx = (q <= 0) ? 64'd0 : (q >> 20);
            raw = (idx < gsab_pkg::EXP_ENTRIES) ? 64'(exp_lut[idx]) : 64'd0;
            alpha = (longint'(f.opac) * raw) >> 16;
            if (alpha > alpha_hi)
                alpha = 64'(alpha_hi);
            if (alpha > 65536)
                alpha = 64'd65536;
            if (alpha >= alpha_lo)
            begin
                w = (alpha * p.trans) >> 16;
                if (w > 0)
                begin
                    inc = (longint'(f.red) * w + 32768) >>> 16;
                    p.r = 16'(clip(longint'(p.r) + inc, -32768, 32767));
                    inc = (longint'(f.green) * w + 32768) >>> 16;
                    p.g = 16'(clip(longint'(p.g) + inc, -32768, 32767));
                    inc = (longint'(f.blue) * w + 32768) >>> 16;
                    p.b = 16'(clip(longint'(p.b) + inc, -32768, 32767));
                    inc = (longint'(f.inv_depth) * w + 32768) >>> 16;
                    p.depth = 32'(clip(longint'(p.depth) + inc, -64'sd2147483648,
                                       64'sd2147483647));
                    p.trans = 17'((longint'(p.trans) * (65536 - alpha) + 32768) >> 16);
                    if (p.cnt != 16'hFFFF)
                        p.cnt = p.cnt + 16'd1;
                    res.blended = 1'b1;
                    pixel_mem[f.pixel] = p;
                end
            end
        end
        res.pixel     = f.pixel;
        res.red       = p.r;
        res.green     = p.g;
        res.blue      = p.b;
        res.trans     = p.trans;
        res.inv_depth = p.depth;
        res.contrib   = p.cnt;
        return res;
    endfunction

    // random fragment; shaped ones land near the splat centre with a small conic
    function automatic frag_t random_frag(input bit shaped);
        frag_t f;
        f.new_frame = 1'b0;
        f.opac      = 17'($urandom_range(0, 65536));
        f.red       = 16'($urandom);
        f.green     = 16'($urandom);
        f.blue      = 16'($urandom);
        f.inv_depth = $urandom;
        if (shaped)
        begin
            f.pixel = 16'($urandom_range(0, 15));
            f.dx    = 16'($signed($urandom_range(0, 160)) - 80);
            f.dy    = 16'($signed($urandom_range(0, 160)) - 80);
            f.ca    = $urandom_range(0, 262144);
            f.cc    = $urandom_range(0, 262144);
            f.cb    = $signed($urandom_range(0, 131072)) - 65536;
            if ($urandom_range(0, 3) == 0)
                f.opac = 17'(65536 - $urandom_range(0, 600));
        end
        else
        begin
            f.pixel = 16'($urandom);
            f.dx    = 16'($urandom);
            f.dy    = 16'($urandom);
            f.ca    = $urandom;
            f.cb    = $urandom;
            f.cc    = $urandom;
        end
        return f;
    endfunction

    function automatic frag_t make_frag(input logic [15:0] pix, input int dx, input int dy,
                                        input int ca, input int cb, input int cc,
                                        input int opac, input int colour, input int idep,
                                        input bit nf);
        frag_t f;
        f.pixel = pix;            f.dx = 16'(dx);            f.dy = 16'(dy);
        f.ca = ca;                f.cb = cb;                 f.cc = cc;
        f.opac = 17'(opac);       f.red = 16'(colour);       f.green = 16'(-colour);
        f.blue = 16'(colour >>> 1);
        f.inv_depth = idep;
        f.new_frame = nf;
        return f;
    endfunction

    task automatic write_reg(input gsab_pkg::cfg_idx_t idx,
                             input logic [gsab_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        case (idx)
            gsab_pkg::CFG_MAX_ALPHA:    alpha_hi = val[16:0];
            gsab_pkg::CFG_MIN_ALPHA:    alpha_lo = val[16:0];
            gsab_pkg::CFG_POWER_CUTOFF: cutoff   = longint'($signed(val));
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (frag_q.size() != 0 || expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // driver: input changes on the falling edge, held until taken
    bit taken;
    always @(posedge clk)
    begin
        taken = 1'b0;
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_q.push_back(composite(frag_q.pop_front()));
            frags_in++;
            taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (s_tvalid && !taken)
            ;
        else if (frag_q.size() != 0 &&
                 ((frags_in >= 600 && frags_in < 800) || $urandom_range(0, 99) >= 20))
        begin
            s_tvalid <= 1'b1;
            s_tuser  <= frag_q[0].new_frame;
            s_tdata  <= {7'd0, frag_q[0].inv_depth, frag_q[0].blue, frag_q[0].green,
                         frag_q[0].red, frag_q[0].opac, frag_q[0].cc, frag_q[0].cb,
                         frag_q[0].ca, frag_q[0].dy, frag_q[0].dx, frag_q[0].pixel};
        end
        else
            s_tvalid <= 1'b0;
    end

    // receiver backpressure
    always @(negedge clk)
    begin
        if (hold_off)
            m_tready <= 1'b0;
        else if (frags_in >= 600 && frags_in < 800)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= 20);
    end

    // long hold on the output while input keeps coming
    initial
    begin
        hold_off = 1'b0;
        wait (frags_in >= 200);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        @(negedge clk);
        hold_off = 1'b0;
    end

    // monitor: compare each result item with the oldest expected pixel
    always @(posedge clk)
    begin
        pix_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
                report("result item with nothing expected");
            else
            begin
                want = expected_q.pop_front();
                if (m_tdata[15:0] !== want.pixel)
                    report($sformatf("pixel %h want %h", m_tdata[15:0], want.pixel));
                if (m_tuser !== want.blended)
                    report($sformatf("blended %b want %b", m_tuser, want.blended));
                if (m_tdata[31:16] !== want.red)
                    report($sformatf("red %h want %h", m_tdata[31:16], want.red));
                if (m_tdata[47:32] !== want.green)
                    report($sformatf("green %h want %h", m_tdata[47:32], want.green));
                if (m_tdata[63:48] !== want.blue)
                    report($sformatf("blue %h want %h", m_tdata[63:48], want.blue));
                if (m_tdata[80:64] !== want.trans)
                    report($sformatf("trans %h want %h", m_tdata[80:64], want.trans));
                if (m_tdata[112:81] !== want.inv_depth)
                    report($sformatf("depth %h want %h", m_tdata[112:81], want.inv_depth));
                if (m_tdata[128:113] !== want.contrib)
                    report($sformatf("count %h want %h", m_tdata[128:113], want.contrib));
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        frag_t f;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_wen   = 1'b0;
        cfg_index = gsab_pkg::CFG_MAX_ALPHA;
        cfg_wdata = '0;
        frags_in  = 0;
        errors    = 0;
        alpha_hi  = gsab_pkg::MAX_ALPHA_RST;
        alpha_lo  = gsab_pkg::MIN_ALPHA_RST;
        cutoff    = longint'($signed(gsab_pkg::POWER_CUTOFF_RST));
        build_exp_lut();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: centre hit, cutoff skip, positive power, weak alpha, extremes
        frag_q.push_back(make_frag(0, 0, 0, 0, 0, 0, 65536, 4096, 65536, 1));
        frag_q.push_back(make_frag(0, 0, 0, 0, 0, 0, 65536, 32767, 32'h7FFFFFFF, 0));
        frag_q.push_back(make_frag(0, 16, 16, 65536, 0, 65536, 65536, -32768,
                                   32'h80000000, 0));
        frag_q.push_back(make_frag(16'hFFFF, 32767, -32768, 32'h7FFFFFFF, 32'h80000000,
                                   32'h7FFFFFFF, 65536, 1000, 1000, 0));
        frag_q.push_back(make_frag(5, 16, 0, -65536, 0, 0, 40000, 2048, 65536, 0));
        frag_q.push_back(make_frag(5, -32768, 32767, 32'h80000000, 32'h7FFFFFFF,
                                   32'h80000000, 65536, 2048, 0, 0));
        frag_q.push_back(make_frag(6, 0, 0, 0, 0, 0, 100, 4096, 65536, 0));
        frag_q.push_back(make_frag(6, 0, 0, 0, 0, 0, 0, 4096, 65536, 0));
        frag_q.push_back(make_frag(7, 32, 32, 32768, 16384, 32768, 65535, 300, 0, 0));
        frag_q.push_back(make_frag(7, 80, -80, 262144, -65536, 262144, 65536, 300, 5, 0));
        for (int i = 0; i < 6; i++)
            frag_q.push_back(make_frag(8, 0, 0, 0, 0, 0, 65536, 32767, 32'h7FFFFFFF, 0));
        wait_idle();

        // phases over register settings, extremes first
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(gsab_pkg::CFG_MAX_ALPHA, 24'd65536);
                    write_reg(gsab_pkg::CFG_MIN_ALPHA, 24'd0);
                    write_reg(gsab_pkg::CFG_POWER_CUTOFF, 24'h800000);
                end
                1:
                begin
                    write_reg(gsab_pkg::CFG_MAX_ALPHA, 24'd0);
                    write_reg(gsab_pkg::CFG_MIN_ALPHA, 24'd65536);
                    write_reg(gsab_pkg::CFG_POWER_CUTOFF, 24'd0);
                end
                2:
                begin
                    write_reg(gsab_pkg::CFG_MAX_ALPHA, 24'($urandom_range(30000, 65536)));
                    write_reg(gsab_pkg::CFG_MIN_ALPHA, 24'($urandom_range(0, 4000)));
                    write_reg(gsab_pkg::CFG_POWER_CUTOFF,
                              24'(-$urandom_range(65536, 8388608)));
                end
                default:
                begin
                    write_reg(gsab_pkg::CFG_MAX_ALPHA, 24'(gsab_pkg::MAX_ALPHA_RST));
                    write_reg(gsab_pkg::CFG_MIN_ALPHA, 24'(gsab_pkg::MIN_ALPHA_RST));
                    write_reg(gsab_pkg::CFG_POWER_CUTOFF, gsab_pkg::POWER_CUTOFF_RST);
                end
            endcase
            for (int i = 0; i < 385; i++)
            begin
                f = random_frag($urandom_range(0, 99) < 75);
                f.new_frame = (i == 0);
                frag_q.push_back(f);
            end
            wait_idle();
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/gsab_pkg.sv
sv/gsab_ram.sv
sv/gsab_ctrl.sv
sv/gsab_dp.sv
sv/gaussian_splat_alpha_blend_unit.sv
tb/tb_top.sv
